FILE: hdl/bfst_pkg.sv
// shared types and constants for the bidirectional flow session table
package bfst_pkg;

   localparam int IDX_W   = 12;
   localparam int CNT_W   = 13;
   localparam int BYTES_W = 24;

   localparam logic [1:0] STATUS_APPEND = 2'd0;
   localparam logic [1:0] STATUS_NEW    = 2'd1;
   localparam logic [1:0] STATUS_DROP   = 2'd2;

   localparam logic [7:0] REG_FILL_LIMIT   = 8'd0;
   localparam logic [7:0] REG_IDLE_TIMEOUT = 8'd1;

   typedef struct packed {
      logic [7:0]         proto;
      logic [31:0]        src_addr;
      logic [31:0]        dst_addr;
      logic [15:0]        src_port;
      logic [15:0]        dst_port;
      logic [31:0]        now;
      logic [BYTES_W-1:0] fill_limit;
      logic [31:0]        idle_timeout;
   } pkt_type;

   typedef struct packed {
      logic               active;
      logic               hit_found;
      logic [IDX_W-1:0]   hit_idx;
      logic [BYTES_W-1:0] hit_bytes;
      logic               hit_pend;
      logic               free_found;
      logic [IDX_W-1:0]   free_idx;
      logic [CNT_W-1:0]   count;
   } carry_type;

   typedef struct packed {
      logic               commit;
      logic               write_en;
      logic               new_entry;
      logic               keep;
      logic [IDX_W-1:0]   slot;
      logic [BYTES_W-1:0] bytes;
   } cmd_type;

endpackage

FILE: hdl/bfst_cell.sv
// one table entry: key, byte total and last-seen time, with match and aging in the scan chain
module bfst_cell
   import bfst_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  pkt_type   pkt,
   input  cmd_type   cmd,
   input  carry_type carry_in,
   output carry_type carry_out
);

   logic               valid_ff, valid_in;
   logic               pend_ff, pend_in;
   logic [7:0]         proto_ff;
   logic [31:0]        src_addr_ff;
   logic [31:0]        dst_addr_ff;
   logic [15:0]        src_port_ff;
   logic [15:0]        dst_port_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic [31:0]        last_ff;
   carry_type          carry_ff, carry_step_in;

   logic        fwd, rev, match, expire, sel;
   logic [31:0] idle;

   assign fwd = (src_addr_ff == pkt.src_addr) && (dst_addr_ff == pkt.dst_addr) &&
                (src_port_ff == pkt.src_port) && (dst_port_ff == pkt.dst_port);
   assign rev = (src_addr_ff == pkt.dst_addr) && (dst_addr_ff == pkt.src_addr) &&
                (src_port_ff == pkt.dst_port) && (dst_port_ff == pkt.src_port);
   assign match  = valid_ff && (proto_ff == pkt.proto) && (fwd || rev);
   assign idle   = pkt.now - last_ff;
   assign expire = valid_ff && ((bytes_ff > pkt.fill_limit) || (idle > pkt.idle_timeout));
   assign sel    = cmd.commit && cmd.write_en && (cmd.slot == IDX_W'(IDX));

   always_comb begin
      carry_step_in = carry_in;
      if (carry_in.active) begin
         if (match && !carry_in.hit_found) begin
            carry_step_in.hit_found = 1'b1;
            carry_step_in.hit_idx   = IDX_W'(IDX);
            carry_step_in.hit_bytes = bytes_ff;
            carry_step_in.hit_pend  = expire;
         end
         if (!valid_ff && !carry_in.free_found) begin
            carry_step_in.free_found = 1'b1;
            carry_step_in.free_idx   = IDX_W'(IDX);
         end
         carry_step_in.count = carry_in.count + CNT_W'(expire);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      pend_in  = pend_ff;
      if (carry_in.active) begin
         pend_in = expire;
      end
      if (cmd.commit) begin
         pend_in = 1'b0;
         if (sel) begin
            valid_in = cmd.keep;
         end else if (pend_ff) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
         carry_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
         carry_ff <= carry_step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         bytes_ff <= cmd.bytes;
         last_ff  <= pkt.now;
         if (cmd.new_entry) begin
            proto_ff    <= pkt.proto;
            src_addr_ff <= pkt.src_addr;
            dst_addr_ff <= pkt.dst_addr;
            src_port_ff <= pkt.src_port;
            dst_port_ff <= pkt.dst_port;
         end
      end
   end

   assign carry_out = carry_ff;

endmodule

FILE: hdl/bidirectional_flow_session_table.sv
// top level of the bidirectional flow session table: control, config and the cell chain
// rsp_tvalid rises when ST_COMMIT finds the output free, after the chain scan and ST_FINAL
// one req word at a time: req_tready is high only in ST_IDLE; the scan token walks the cell chain
//   one cell per cycle; the next req word is taken while a rsp word waits
// reset: synchronous; clears all entries, restores fill_limit 49152 and idle_timeout 30
module bidirectional_flow_session_table
   import bfst_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // protocol, src_addr, dst_addr, src_port, dst_port, data_len, now_seconds
   input  logic [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, slot, session_bytes, session_closed, closed_count
   output logic [39:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [31:0]  csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINAL,
      ST_COMMIT
   } state_type;

   state_type state_ff;

   logic [BYTES_W-1:0] fill_limit_ff;
   logic [31:0]        idle_timeout_ff;

   logic [7:0]  proto_ff;
   logic [31:0] src_addr_ff, dst_addr_ff, now_ff;
   logic [15:0] src_port_ff, dst_port_ff, len_ff;

   carry_type start_ff, start_in;
   carry_type scan_ff;
   carry_type chain [ENTRIES+1];

   logic [1:0]         status_ff;
   logic [IDX_W-1:0]   slot_ff;
   logic [BYTES_W-1:0] new_bytes_ff;
   logic               closed_ff;
   logic [CNT_W-1:0]   count_ff;

   logic        rsp_tvalid_ff;
   logic [39:0] rsp_tdata_ff;

   logic        req_accept, out_free, commit_go;
   logic [BYTES_W:0]   sum;
   logic [BYTES_W-1:0] sat_bytes, bytes_calc;
   logic [1:0]         status_calc;
   logic               close_calc;
   logic [CNT_W-1:0]   count_calc;
   logic [IDX_W-1:0]   slot_calc;

   pkt_type pkt;
   cmd_type cmd;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign commit_go  = (state_ff == ST_COMMIT) && out_free;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign pkt.proto        = proto_ff;
   assign pkt.src_addr     = src_addr_ff;
   assign pkt.dst_addr     = dst_addr_ff;
   assign pkt.src_port     = src_port_ff;
   assign pkt.dst_port     = dst_port_ff;
   assign pkt.now          = now_ff;
   assign pkt.fill_limit   = fill_limit_ff;
   assign pkt.idle_timeout = idle_timeout_ff;

   assign cmd.commit    = commit_go;
   assign cmd.write_en  = (status_ff != STATUS_DROP);
   assign cmd.new_entry = (status_ff == STATUS_NEW);
   assign cmd.keep      = !closed_ff;
   assign cmd.slot      = slot_ff;
   assign cmd.bytes     = new_bytes_ff;

   assign chain[0] = start_ff;

   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      bfst_cell #(
         .IDX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .pkt       (pkt),
         .cmd       (cmd),
         .carry_in  (chain[k]),
         .carry_out (chain[k+1])
      );
   end

   always_comb begin
      start_in        = '0;
      start_in.active = req_accept;
   end

   always_comb begin
      sum       = {1'b0, scan_ff.hit_bytes} + (BYTES_W+1)'(len_ff);
      sat_bytes = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
      if (scan_ff.hit_found) begin
         status_calc = STATUS_APPEND;
         slot_calc   = scan_ff.hit_idx;
         bytes_calc  = sat_bytes;
      end else if (scan_ff.free_found) begin
         status_calc = STATUS_NEW;
         slot_calc   = scan_ff.free_idx;
         bytes_calc  = BYTES_W'(len_ff);
      end else begin
         status_calc = STATUS_DROP;
         slot_calc   = '0;
         bytes_calc  = '0;
      end
      close_calc = (status_calc != STATUS_DROP) && (bytes_calc > fill_limit_ff);
      count_calc = scan_ff.count - CNT_W'(scan_ff.hit_found && scan_ff.hit_pend)
                   + CNT_W'(close_calc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         start_ff        <= '0;
         scan_ff         <= '0;
         rsp_tvalid_ff   <= 1'b0;
         fill_limit_ff   <= BYTES_W'(49152);
         idle_timeout_ff <= 32'd30;
      end else begin
         start_ff <= start_in;
         if (commit_go) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               REG_FILL_LIMIT:   fill_limit_ff   <= csr_data[BYTES_W-1:0];
               REG_IDLE_TIMEOUT: idle_timeout_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (chain[ENTRIES].active) begin
                  scan_ff  <= chain[ENTRIES];
                  state_ff <= ST_FINAL;
               end
            end
            ST_FINAL: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         proto_ff    <= req_tdata[7:0];
         src_addr_ff <= req_tdata[39:8];
         dst_addr_ff <= req_tdata[71:40];
         src_port_ff <= req_tdata[87:72];
         dst_port_ff <= req_tdata[103:88];
         len_ff      <= req_tdata[119:104];
         now_ff      <= req_tdata[151:120];
      end
      if (state_ff == ST_FINAL) begin
         status_ff    <= status_calc;
         slot_ff      <= slot_calc;
         new_bytes_ff <= bytes_calc;
         closed_ff    <= close_calc;
         count_ff     <= count_calc;
      end
      if (commit_go) begin
         rsp_tdata_ff <= {count_ff[6:0], closed_ff, new_bytes_ff, slot_ff[5:0], status_ff};
      end
   end

endmodule
